@@ hw/rtl/stq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;
   localparam logic [1:0] FUNC_QUERY    = 2'd3;

   // Result status codes carried on rsp_tuser
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_QUEUED   = 2'd1;
   localparam logic [1:0] STATUS_EXPIRED  = 2'd2;
   localparam logic [1:0] STATUS_NONE_DUE = 2'd3;

   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int TIME_W      = 32;
   localparam int TICKS_W     = 24;
   localparam int ID_W        = 4;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] fired_id;
      logic            is_queued;
      logic            last;
   } stq_beat_type;

   typedef enum logic [3:0] {
      STQ_IDLE,
      STQ_RESP,
      STQ_T_CHECK,
      STQ_T_WAIT,
      STQ_T_EVAL,
      STQ_T_FINISH,
      STQ_L_STEP,
      STQ_L_WAIT,
      STQ_L_EVAL,
      STQ_L_LINK1,
      STQ_L_LINK2,
      STQ_U_STEP,
      STQ_U_WAIT,
      STQ_U_EVAL
   } stq_state_type;

   // a is earlier than b when the wrapping difference is negative
   function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stq_rsp_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stq_rsp_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load_en,
   input  stq_pkg::stq_beat_type beat,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,   // fired_id [3:0], is_queued [4], zero [7:5]
   output logic [1:0]           rsp_tuser,   // status [1:0]
   output logic                 rsp_tlast
);

   logic                  valid_ff;
   logic                  valid_in;
   stq_pkg::stq_beat_type beat_ff;

   // slot frees when empty or when the held beat leaves this cycle
   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load_en ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         beat_ff <= beat;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, beat_ff.is_queued, beat_ff.fired_id};
   assign rsp_tuser  = beat_ff.status;
   assign rsp_tlast  = beat_ff.last;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_timer_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer queue: up to NUM_TIMERS timers in a linked list ordered by deadline.
// Request channel (req_*): one beat per command; req_tuser selects schedule, cancel,
// tick or query, req_tdata carries timer id, delay and period.
// Response channel (rsp_*): schedule, cancel and query answer with exactly one beat;
// a tick answers with one beat per expired timer (at most 16), or one "none due"
// beat, and rsp_tlast marks the final beat of each command.
// Deadlines, reload periods and next links live in synchronous RAMs with a registered
// read; every list step is read, wait, evaluate.
// Query, cancel of an idle timer and refused schedule go straight to the response;
// schedule walks the entries ahead of the new one, then links it in, with one more
// link write when it is not the new head; cancel walks the entries before the timer.
// A tick pops expired entries from the head until one is not yet due, the list is
// empty or the cap is reached, with a schedule walk for each periodic timer reloaded.
// One command is in flight at a time: req_tready is high only while the sequencer
// sits idle. Reset clears the time counter, the queued flags and the list head; RAM
// contents are left as they are and are read only for queued timers.
// A stalled receiver holds the response register; the sequencer waits on it and
// resumes with no loss once the beat is taken.
module sorted_timer_queue_unit #(
   parameter int NUM_TIMERS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // timer_id [3:0], delay_ticks [27:4],
                                    // period_ticks [51:28], zero [55:52]
   input  wire  [1:0]  req_tuser,   // func [1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // fired_id [3:0], is_queued [4], zero [7:5]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tlast
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NIL = {LW{1'b1}};
   localparam int TW = stq_pkg::TIME_W;
   localparam int PW = stq_pkg::TICKS_W;
   localparam int CW = stq_pkg::CNT_W;

   // Request fields
   logic [stq_pkg::ID_W-1:0] req_timer_id;
   logic [PW-1:0]            req_delay_ticks;
   logic [PW-1:0]            req_period_ticks;
   logic [1:0]               req_func;

   assign req_timer_id     = req_tdata[3:0];
   assign req_delay_ticks  = req_tdata[27:4];
   assign req_period_ticks = req_tdata[51:28];
   assign req_func         = req_tuser;

   // Timer state RAMs
   logic [TW-1:0] dline_mem [NUM_TIMERS];
   logic [PW-1:0] reload_mem [NUM_TIMERS];
   logic [LW-1:0] link_mem [NUM_TIMERS];

   logic [TW-1:0] dl_rd_ff;
   logic [PW-1:0] rl_rd_ff;
   logic [LW-1:0] lk_rd_ff;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          dl_we;
   logic [IW-1:0] dl_wa;
   logic [TW-1:0] dl_wd;
   logic [PW-1:0] rl_wd;
   logic          lk_we;
   logic [IW-1:0] lk_wa;
   logic [LW-1:0] lk_wd;

   // Control registers
   stq_pkg::stq_state_type state_ff, state_in;
   logic [TW-1:0]          now_ff, now_in;
   logic [LW-1:0]          head_ff, head_in;
   logic [NUM_TIMERS-1:0]  queued_ff, queued_in;
   logic [IW-1:0]          id_ff, id_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [LW-1:0]          prev_ff, prev_in;
   logic [TW-1:0]          dline_ff, dline_in;
   stq_pkg::stq_beat_type  res_ff, res_in;
   logic                   pend_ff, pend_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   in_tick_ff, in_tick_in;

   // Response stage hookup
   logic                  out_free;
   logic                  beat_load;
   stq_pkg::stq_beat_type beat;

   // Shared decode
   logic          req_fire;
   logic          id_ok;
   logic [IW-1:0] req_idx;
   logic          req_queued;
   logic [IW-1:0] head_idx;
   logic          due;
   logic          rl_nonzero;
   logic [TW-1:0] reload_sum;
   logic          ins_here;
   logic          cnt_full;
   logic          hit_id;

   assign req_fire   = req_tvalid && req_tready;
   assign id_ok      = 32'(req_timer_id) < NUM_TIMERS;
   assign req_idx    = IW'(req_timer_id);
   assign req_queued = id_ok && queued_ff[req_idx];
   assign head_idx   = head_ff[IW-1:0];
   assign due        = !stq_pkg::earlier(now_ff, dl_rd_ff);
   assign rl_nonzero = rl_rd_ff != '0;
   assign reload_sum = dl_rd_ff + TW'(rl_rd_ff);
   assign ins_here   = stq_pkg::earlier(dline_ff, dl_rd_ff);
   assign cnt_full   = cnt_ff == CW'(stq_pkg::MAX_RESULTS);
   assign hit_id     = cur_ff == {1'b0, id_ff};

   assign req_tready = state_ff == stq_pkg::STQ_IDLE;

   // RAM ports: one write per array, one shared read address, registered read
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dline_mem[dl_wa]  <= dl_wd;
         reload_mem[dl_wa] <= rl_wd;
      end
      if (lk_we) begin
         link_mem[lk_wa] <= lk_wd;
      end
      if (rd_en) begin
         dl_rd_ff <= dline_mem[rd_addr];
         rl_rd_ff <= reload_mem[rd_addr];
         lk_rd_ff <= link_mem[rd_addr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stq_pkg::STQ_IDLE: begin
            if (req_fire) begin
               if (req_func == stq_pkg::FUNC_TICK) begin
                  state_in = stq_pkg::STQ_T_CHECK;
               end else if (!id_ok) begin
                  state_in = stq_pkg::STQ_RESP;
               end else if (req_func == stq_pkg::FUNC_SCHEDULE && !req_queued) begin
                  state_in = stq_pkg::STQ_L_STEP;
               end else if (req_func == stq_pkg::FUNC_CANCEL && req_queued) begin
                  state_in = stq_pkg::STQ_U_STEP;
               end else begin
                  state_in = stq_pkg::STQ_RESP;
               end
            end
         end
         stq_pkg::STQ_RESP: begin
            if (out_free) begin
               state_in = stq_pkg::STQ_IDLE;
            end
         end
         stq_pkg::STQ_T_CHECK: begin
            if (cnt_full || head_ff == NIL) begin
               state_in = stq_pkg::STQ_T_FINISH;
            end else begin
               state_in = stq_pkg::STQ_T_WAIT;
            end
         end
         stq_pkg::STQ_T_WAIT: begin
            state_in = stq_pkg::STQ_T_EVAL;
         end
         stq_pkg::STQ_T_EVAL: begin
            if (!due) begin
               state_in = stq_pkg::STQ_T_FINISH;
            end else if (!pend_ff || out_free) begin
               state_in = rl_nonzero ? stq_pkg::STQ_L_STEP : stq_pkg::STQ_T_CHECK;
            end
         end
         stq_pkg::STQ_T_FINISH: begin
            if (out_free) begin
               state_in = stq_pkg::STQ_IDLE;
            end
         end
         stq_pkg::STQ_L_STEP: begin
            state_in = (cur_ff == NIL) ? stq_pkg::STQ_L_LINK1 : stq_pkg::STQ_L_WAIT;
         end
         stq_pkg::STQ_L_WAIT: begin
            state_in = stq_pkg::STQ_L_EVAL;
         end
         stq_pkg::STQ_L_EVAL: begin
            state_in = ins_here ? stq_pkg::STQ_L_LINK1 : stq_pkg::STQ_L_STEP;
         end
         stq_pkg::STQ_L_LINK1: begin
            if (prev_ff != NIL) begin
               state_in = stq_pkg::STQ_L_LINK2;
            end else begin
               state_in = in_tick_ff ? stq_pkg::STQ_T_CHECK : stq_pkg::STQ_RESP;
            end
         end
         stq_pkg::STQ_L_LINK2: begin
            state_in = in_tick_ff ? stq_pkg::STQ_T_CHECK : stq_pkg::STQ_RESP;
         end
         stq_pkg::STQ_U_STEP: begin
            state_in = (cur_ff == NIL) ? stq_pkg::STQ_RESP : stq_pkg::STQ_U_WAIT;
         end
         stq_pkg::STQ_U_WAIT: begin
            state_in = stq_pkg::STQ_U_EVAL;
         end
         stq_pkg::STQ_U_EVAL: begin
            state_in = hit_id ? stq_pkg::STQ_RESP : stq_pkg::STQ_U_STEP;
         end
         default: begin
            state_in = stq_pkg::STQ_IDLE;
         end
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      now_in     = now_ff;
      head_in    = head_ff;
      queued_in  = queued_ff;
      id_in      = id_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      dline_in   = dline_ff;
      res_in     = res_ff;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      in_tick_in = in_tick_ff;
      rd_en      = 1'b0;
      rd_addr    = cur_ff[IW-1:0];
      dl_we      = 1'b0;
      dl_wa      = id_ff;
      dl_wd      = dline_ff;
      rl_wd      = rl_rd_ff;
      lk_we      = 1'b0;
      lk_wa      = id_ff;
      lk_wd      = cur_ff;
      beat_load  = 1'b0;
      beat       = res_ff;
      unique case (state_ff)
         stq_pkg::STQ_IDLE: begin
            if (req_fire) begin
               res_in.fired_id  = req_timer_id;
               res_in.status    = stq_pkg::STATUS_DONE;
               res_in.is_queued = 1'b0;
               res_in.last      = 1'b1;
               id_in            = req_idx;
               cur_in           = head_ff;
               prev_in          = NIL;
               in_tick_in       = 1'b0;
               if (req_func == stq_pkg::FUNC_TICK) begin
                  now_in     = now_ff + TW'(1);
                  cnt_in     = '0;
                  pend_in    = 1'b0;
                  in_tick_in = 1'b1;
               end else if (id_ok) begin
                  case (req_func)
                     stq_pkg::FUNC_SCHEDULE: begin
                        res_in.is_queued = 1'b1;
                        if (req_queued) begin
                           res_in.status = stq_pkg::STATUS_QUEUED;
                        end else begin
                           dl_we    = 1'b1;
                           dl_wa    = req_idx;
                           dl_wd    = now_ff + TW'(req_delay_ticks);
                           rl_wd    = req_period_ticks;
                           dline_in = now_ff + TW'(req_delay_ticks);
                        end
                     end
                     stq_pkg::FUNC_QUERY: begin
                        res_in.is_queued = req_queued;
                     end
                     default: begin
                        // cancel answers not queued whether or not a walk follows
                        res_in.is_queued = 1'b0;
                     end
                  endcase
               end
            end
         end
         stq_pkg::STQ_RESP: begin
            beat      = res_ff;
            beat_load = out_free;
         end
         stq_pkg::STQ_T_CHECK: begin
            if (!cnt_full && head_ff != NIL) begin
               rd_en   = 1'b1;
               rd_addr = head_idx;
            end
         end
         stq_pkg::STQ_T_WAIT: begin
            // hold while the head entry is read
         end
         stq_pkg::STQ_T_EVAL: begin
            if (due && (!pend_ff || out_free)) begin
               // release the previous expiry now that another one follows
               beat      = res_ff;
               beat.last = 1'b0;
               beat_load = pend_ff;
               // pop the head and record its expiry
               head_in             = lk_rd_ff;
               queued_in[head_idx] = 1'b0;
               res_in.status       = stq_pkg::STATUS_EXPIRED;
               res_in.fired_id     = stq_pkg::ID_W'(head_idx);
               res_in.is_queued    = rl_nonzero;
               res_in.last         = 1'b1;
               pend_in             = 1'b1;
               cnt_in              = cnt_ff + CW'(1);
               if (rl_nonzero) begin
                  // reload: advance the deadline and walk from the new head
                  dl_we    = 1'b1;
                  dl_wa    = head_idx;
                  dl_wd    = reload_sum;
                  rl_wd    = rl_rd_ff;
                  dline_in = reload_sum;
                  id_in    = head_idx;
                  cur_in   = lk_rd_ff;
                  prev_in  = NIL;
               end
            end
         end
         stq_pkg::STQ_T_FINISH: begin
            if (pend_ff) begin
               beat      = res_ff;
               beat.last = 1'b1;
            end else begin
               beat.status    = stq_pkg::STATUS_NONE_DUE;
               beat.fired_id  = '0;
               beat.is_queued = 1'b0;
               beat.last      = 1'b1;
            end
            beat_load = out_free;
         end
         stq_pkg::STQ_L_STEP: begin
            if (cur_ff != NIL) begin
               rd_en   = 1'b1;
               rd_addr = cur_ff[IW-1:0];
            end
         end
         stq_pkg::STQ_L_WAIT: begin
            // hold while the entry is read
         end
         stq_pkg::STQ_L_EVAL: begin
            // equal deadlines pass, so the new timer lands after them
            if (!ins_here) begin
               prev_in = cur_ff;
               cur_in  = lk_rd_ff;
            end
         end
         stq_pkg::STQ_L_LINK1: begin
            lk_we            = 1'b1;
            lk_wa            = id_ff;
            lk_wd            = cur_ff;
            queued_in[id_ff] = 1'b1;
            if (prev_ff == NIL) begin
               head_in = {1'b0, id_ff};
            end
         end
         stq_pkg::STQ_L_LINK2: begin
            lk_we = 1'b1;
            lk_wa = prev_ff[IW-1:0];
            lk_wd = {1'b0, id_ff};
         end
         stq_pkg::STQ_U_STEP: begin
            if (cur_ff == NIL) begin
               queued_in[id_ff] = 1'b0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff[IW-1:0];
            end
         end
         stq_pkg::STQ_U_WAIT: begin
            // hold while the entry is read
         end
         stq_pkg::STQ_U_EVAL: begin
            if (hit_id) begin
               // splice the successor into the predecessor or the head
               queued_in[id_ff] = 1'b0;
               if (prev_ff != NIL) begin
                  lk_we = 1'b1;
                  lk_wa = prev_ff[IW-1:0];
                  lk_wd = lk_rd_ff;
               end else begin
                  head_in = lk_rd_ff;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = lk_rd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= stq_pkg::STQ_IDLE;
         now_ff     <= '0;
         head_ff    <= NIL;
         queued_ff  <= '0;
         pend_ff    <= 1'b0;
         cnt_ff     <= '0;
         in_tick_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         now_ff     <= now_in;
         head_ff    <= head_in;
         queued_ff  <= queued_in;
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
         in_tick_ff <= in_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      dline_ff <= dline_in;
      res_ff   <= res_in;
   end

   stq_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_en    (beat_load),
      .beat       (beat),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_timer_queue_unit.sv @@
`timescale 1ns / 1ps

// Checks the sorted timer queue: a table of hand-picked commands, then random
// command sequences, all run against a shadow copy of the timer list.
module tb_sorted_timer_queue_unit;

   localparam int SLOTS       = 16;
   localparam int NO_LINK     = SLOTS;
   localparam int RANDOM_CMDS = 90;

   // One command beat; rows typed in by hand also carry their single response.
   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [23:0] delay;
      logic [23:0] period;
      logic        typed;
      logic [1:0]  w_status;
      logic        w_queued;
   } plan_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // timer_id [3:0], delay [27:4], period [51:28], zero [55:52]
   logic [1:0]  req_tuser  = stq_pkg::FUNC_SCHEDULE;   // func [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // fired_id [3:0], is_queued [4], zero [7:5]
   logic [1:0]  rsp_tuser;         // status [1:0]
   logic        rsp_tlast;

   // Shadow of the timer list
   logic [31:0] sh_now;
   logic [31:0] sh_deadline [SLOTS];
   logic [23:0] sh_reload [SLOTS];
   bit          sh_armed [SLOTS];
   int          sh_next [SLOTS];
   int          sh_head;

   stq_pkg::stq_beat_type rsp_backlog [$];   // response beats still owed by the block
   stq_pkg::stq_beat_type step_beats [stq_pkg::MAX_RESULTS]; // beats of the latest command
   plan_row_type plan [$];

   int err_count     = 0;
   int cmds_sent     = 0;
   int beats_checked = 0;
   int expiries      = 0;
   int widest_burst  = 0;
   int hold_left     = 0;
   bit steady        = 1'b0;

   sorted_timer_queue_unit #(.NUM_TIMERS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs or owes beats forever
   initial begin
      #10_000_000;
      $display("tb_sorted_timer_queue_unit: timeout with %0d beats outstanding",
               rsp_backlog.size());
      $display("tb_sorted_timer_queue_unit: FAIL");
      $finish;
   end

   function automatic stq_pkg::stq_beat_type mk_beat(input logic [1:0] status,
                                                     input logic [3:0] id,
                                                     input logic queued, input logic last);
      stq_pkg::stq_beat_type b;
      b.status    = status;
      b.fired_id  = id;
      b.is_queued = queued;
      b.last      = last;
      return b;
   endfunction

   function automatic plan_row_type mk_row(input logic [1:0] op, input logic [3:0] slot,
                                           input logic [23:0] delay, input logic [23:0] period,
                                           input logic typed = 1'b0,
                                           input logic [1:0] w_status = stq_pkg::STATUS_DONE,
                                           input logic w_queued = 1'b0);
      plan_row_type r;
      r.op       = op;
      r.slot     = slot;
      r.delay    = delay;
      r.period   = period;
      r.typed    = typed;
      r.w_status = w_status;
      r.w_queued = w_queued;
      return r;
   endfunction

   // Mostly short gaps, a few long ones; none at all during a steady phase.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // a lies before b when the 32-bit wrapping difference is negative
   function automatic bit runs_ahead(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] delta;
      delta = a - b;
      return delta[31];
   endfunction

   // Insert after every timer whose deadline is not later, so ties keep arrival order.
   function automatic void link_timer(input int id);
      int prev;
      int cur;
      prev = NO_LINK;
      cur  = sh_head;
      while (cur != NO_LINK && !runs_ahead(sh_deadline[id], sh_deadline[cur])) begin
         prev = cur;
         cur  = sh_next[cur];
      end
      sh_next[id] = cur;
      if (prev != NO_LINK) sh_next[prev] = id;
      else sh_head = id;
      sh_armed[id] = 1'b1;
   endfunction

   function automatic void unlink_timer(input int id);
      int prev;
      int cur;
      prev = NO_LINK;
      cur  = sh_head;
      while (cur != NO_LINK && cur != id) begin
         prev = cur;
         cur  = sh_next[cur];
      end
      if (cur == id) begin
         if (prev != NO_LINK) sh_next[prev] = sh_next[id];
         else sh_head = sh_next[id];
      end
      sh_next[id]  = NO_LINK;
      sh_armed[id] = 1'b0;
   endfunction

   // Apply one command to the shadow list; fill step_beats and return how many.
   function automatic int apply_timer_cmd(input logic [1:0] op, input logic [3:0] slot,
                                          input logic [23:0] delay, input logic [23:0] period);
      int n;
      int h;
      int k;
      int id;
      int fired [stq_pkg::MAX_RESULTS];
      n  = 0;
      id = slot;
      case (op)
         stq_pkg::FUNC_TICK: begin
            sh_now = sh_now + 32'd1;
            // Pop due timers from the head; a periodic one goes back in and may be due again.
            while (n < stq_pkg::MAX_RESULTS && sh_head != NO_LINK) begin
               h = sh_head;
               if (runs_ahead(sh_now, sh_deadline[h])) break;
               sh_head     = sh_next[h];
               sh_next[h]  = NO_LINK;
               sh_armed[h] = 1'b0;
               if (sh_reload[h] != 24'd0) begin
                  sh_deadline[h] = sh_deadline[h] + {8'd0, sh_reload[h]};
                  link_timer(h);
               end
               fired[n] = h;
               n++;
            end
            if (n == 0) begin
               step_beats[0] = mk_beat(stq_pkg::STATUS_NONE_DUE, 4'd0, 1'b0, 1'b1);
               return 1;
            end
            // is_queued reflects the list once the whole tick is over
            for (k = 0; k < n; k++)
               step_beats[k] = mk_beat(stq_pkg::STATUS_EXPIRED, 4'(fired[k]),
                                       sh_armed[fired[k]], k == n - 1);
            return n;
         end
         stq_pkg::FUNC_SCHEDULE: begin
            if (sh_armed[id]) begin
               step_beats[0] = mk_beat(stq_pkg::STATUS_QUEUED, slot, 1'b1, 1'b1);
               return 1;
            end
            sh_deadline[id] = sh_now + {8'd0, delay};
            sh_reload[id]   = period;
            link_timer(id);
            step_beats[0] = mk_beat(stq_pkg::STATUS_DONE, slot, 1'b1, 1'b1);
            return 1;
         end
         stq_pkg::FUNC_CANCEL: begin
            if (sh_armed[id]) unlink_timer(id);
            step_beats[0] = mk_beat(stq_pkg::STATUS_DONE, slot, 1'b0, 1'b1);
            return 1;
         end
         default: begin
            step_beats[0] = mk_beat(stq_pkg::STATUS_DONE, slot, sh_armed[id], 1'b1);
            return 1;
         end
      endcase
   endfunction

   task automatic report_bad(input string what);
      err_count++;
      $display("tb_sorted_timer_queue_unit: mismatch at %0t: %s", $time, what);
   endtask

   // Offer one command beat, hold it until taken, then log the beats it owes.
   task automatic issue_cmd(input plan_row_type row);
      int gap;
      int n;
      int k;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= {4'd0, row.period, row.delay, row.slot};
      do @(posedge clock); while (!req_tready);
      n = apply_timer_cmd(row.op, row.slot, row.delay, row.period);
      if (row.typed) begin
         rsp_backlog.push_back(mk_beat(row.w_status, row.slot, row.w_queued, 1'b1));
      end else begin
         for (k = 0; k < n; k++) rsp_backlog.push_back(step_beats[k]);
      end
      if (row.op == stq_pkg::FUNC_TICK && step_beats[0].status == stq_pkg::STATUS_EXPIRED) begin
         expiries += n;
         if (n > widest_burst) widest_burst = n;
      end
      cmds_sent++;
   endtask

   // Arm a few timers with short delays, then mostly tick with some cancels and queries.
   task automatic run_arm_and_tick();
      int k;
      int count;
      count = $urandom_range(1, 6);
      for (k = 0; k < count; k++)
         issue_cmd(mk_row(stq_pkg::FUNC_SCHEDULE, 4'($urandom), 24'($urandom_range(0, 8)),
                          ($urandom_range(0, 2) == 0) ? 24'($urandom_range(1, 6)) : 24'd0));
      count = $urandom_range(1, 10);
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 5))
            0: issue_cmd(mk_row(stq_pkg::FUNC_CANCEL, 4'($urandom), 24'($urandom),
                                24'($urandom)));
            1: issue_cmd(mk_row(stq_pkg::FUNC_QUERY, 4'($urandom), 24'($urandom),
                                24'($urandom)));
            default: issue_cmd(mk_row(stq_pkg::FUNC_TICK, 4'($urandom), 24'($urandom),
                                      24'($urandom)));
         endcase
      end
   endtask

   // Arm every idle timer due at once, the first with period one so that it lags
   // behind the burst cap; tick a few times, then cancel whatever is left.
   task automatic run_flood();
      int k;
      int first;
      int id;
      first = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < SLOTS; k++) begin
         id = (first + k) % SLOTS;
         if (!sh_armed[id])
            issue_cmd(mk_row(stq_pkg::FUNC_SCHEDULE, 4'(id), 24'd0,
                             (k == 0) ? 24'd1 : 24'($urandom_range(0, 3))));
      end
      repeat ($urandom_range(2, 4))
         issue_cmd(mk_row(stq_pkg::FUNC_TICK, 4'($urandom), 24'd0, 24'd0));
      for (id = 0; id < SLOTS; id++)
         if (sh_armed[id])
            issue_cmd(mk_row(stq_pkg::FUNC_CANCEL, 4'(id), 24'($urandom), 24'($urandom)));
   endtask

   // Any command with full-range fields
   task automatic run_noise();
      repeat ($urandom_range(2, 6))
         issue_cmd(mk_row(2'($urandom), 4'($urandom), 24'($urandom), 24'($urandom)));
   endtask

   // Receiver: hold rsp_tready low for random stretches, never during a steady phase
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
   end

   // Compare every accepted response beat with the oldest one owed
   always @(posedge clock) begin : rsp_check
      stq_pkg::stq_beat_type got;
      stq_pkg::stq_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk_beat(rsp_tuser, rsp_tdata[3:0], rsp_tdata[4], rsp_tlast);
         beats_checked++;
         if (rsp_backlog.size() == 0) begin
            report_bad($sformatf("beat with none owed: status %0d id %0d queued %0d last %0d",
                                 got.status, got.fired_id, got.is_queued, got.last));
         end else begin
            want = rsp_backlog.pop_front();
            if (got.status != want.status)
               report_bad($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.fired_id != want.fired_id)
               report_bad($sformatf("fired_id %0d, want %0d", got.fired_id, want.fired_id));
            if (got.is_queued != want.is_queued)
               report_bad($sformatf("is_queued %0d, want %0d (id %0d)",
                                    got.is_queued, want.is_queued, want.fired_id));
            if (got.last != want.last)
               report_bad($sformatf("last %0d, want %0d (id %0d)",
                                    got.last, want.last, want.fired_id));
         end
      end
   end

   initial begin : stimulus
      int i;
      int directed;
      int pick;

      sh_now  = '0;
      sh_head = NO_LINK;
      for (i = 0; i < SLOTS; i++) begin
         sh_deadline[i] = '0;
         sh_reload[i]   = '0;
         sh_armed[i]    = 1'b0;
         sh_next[i]     = NO_LINK;
      end

      // Empty list after reset, idle cancel, refused reschedule, extreme fields
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_NONE_DUE, 1'b0));
      plan.push_back(mk_row(stq_pkg::FUNC_QUERY, 4'd0, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      plan.push_back(mk_row(stq_pkg::FUNC_CANCEL, 4'd15, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd0, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b1));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd0, 24'd5, 24'd7,
                            1'b1, stq_pkg::STATUS_QUEUED, 1'b1));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd15, 24'hFFFFFF, 24'hFFFFFF,
                            1'b1, stq_pkg::STATUS_DONE, 1'b1));
      plan.push_back(mk_row(stq_pkg::FUNC_QUERY, 4'd15, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b1));
      // Equal deadlines must come out in arrival order; timer 1 reloads every 3 ticks
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd2, 24'd1, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd3, 24'd1, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd1, 24'd1, 24'd3));
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd4, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_QUERY, 4'd1, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd9, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_CANCEL, 4'd1, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      plan.push_back(mk_row(stq_pkg::FUNC_QUERY, 4'd1, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      plan.push_back(mk_row(stq_pkg::FUNC_CANCEL, 4'd15, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      // Alternating bit patterns in delay and period
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd5, 24'hAAAAAA, 24'h555555,
                            1'b1, stq_pkg::STATUS_DONE, 1'b1));
      plan.push_back(mk_row(stq_pkg::FUNC_CANCEL, 4'd5, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      // A period-one timer that is already due fires twice in the first tick
      plan.push_back(mk_row(stq_pkg::FUNC_SCHEDULE, 4'd6, 24'd0, 24'd1,
                            1'b1, stq_pkg::STATUS_DONE, 1'b1));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_TICK, 4'd0, 24'd0, 24'd0));
      plan.push_back(mk_row(stq_pkg::FUNC_CANCEL, 4'd6, 24'd0, 24'd0,
                            1'b1, stq_pkg::STATUS_DONE, 1'b0));
      directed = plan.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed; i++) issue_cmd(plan[i]);

      // Hit the burst cap once for sure, then draw sequences until enough commands went out
      run_flood();
      while (cmds_sent - directed < RANDOM_CMDS) begin
         steady = ($urandom_range(0, 3) == 0);
         pick   = $urandom_range(0, 99);
         if (pick < 60) run_arm_and_tick();
         else if (pick < 75) run_flood();
         else run_noise();
      end
      steady = 1'b0;

      // Drain, then watch a little longer for stray beats
      req_tvalid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("tb_sorted_timer_queue_unit: %0d commands (%0d from the table), %0d beats checked",
               cmds_sent, directed, beats_checked);
      $display("tb_sorted_timer_queue_unit: %0d expiries, up to %0d in one tick, %0d mismatches",
               expiries, widest_burst, err_count);
      if (err_count == 0) begin
         $display("tb_sorted_timer_queue_unit: PASS");
      end else begin
         $display("tb_sorted_timer_queue_unit: FAIL");
      end
      $finish;
   end

endmodule
